// File: hw/rtl/imtf_pkg.sv
// Shared types and constants of the interleaved move-to-front codec.
package imtf_pkg;

  // Symbol alphabet and derived widths.
  localparam int unsigned Alphabet = 256;
  localparam int unsigned SymW     = 8;
  // Fill count per lane runs from 0 to Alphabet.
  localparam int unsigned FillW    = 9;
  // Lane count arithmetic; wide enough for the largest lane limit.
  localparam int unsigned CntW     = 7;
  localparam int unsigned CfgDataW = 6;

  // Configuration register indexes.
  localparam logic RegMode      = 1'b0;
  localparam logic RegLaneCount = 1'b1;

  // Mode codes.
  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic [CfgDataW-1:0] LaneCountReset = 6'd16;

  // Sequencer states.
  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StLookup  = 5'b00010,
    StLookupW = 5'b00100,
    StWalk    = 5'b01000,
    StDone    = 5'b10000
  } state_e;

  // Command from the top level to the sequencer.
  typedef struct packed {
    logic            valid;
    logic            decode;
    logic            eob;
    logic [SymW-1:0] sym;
  } start_t;

  // Finished result from the sequencer.
  typedef struct packed {
    logic            valid;
    logic [SymW-1:0] result;
  } done_t;

endpackage

// File: hw/rtl/imtf_list_mem.sv
// Recency list storage: one write port and one registered read port.
module imtf_list_mem #(
  parameter int unsigned AddrW = 13
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [imtf_pkg::SymW-1:0] wdata_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [imtf_pkg::SymW-1:0] rdata_o
);

  logic [imtf_pkg::SymW-1:0] mem [2**AddrW];
  logic [imtf_pkg::SymW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/imtf_ctrl.sv
// Sequencer that searches and shifts one lane list, one entry per cycle.
module imtf_ctrl #(
  parameter int unsigned MAX_LANES = 32,
  parameter int unsigned LaneW     = 5,
  parameter int unsigned AddrW     = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  imtf_pkg::start_t          start_i,
  input  logic [LaneW-1:0]          lane_i,
  output logic                      idle_o,
  output imtf_pkg::done_t           done_o,
  input  logic                      done_ack_i,
  output logic                      mem_we_o,
  output logic [AddrW-1:0]          mem_waddr_o,
  output logic [imtf_pkg::SymW-1:0] mem_wdata_o,
  output logic [AddrW-1:0]          mem_raddr_o,
  input  logic [imtf_pkg::SymW-1:0] mem_rdata_i
);

  localparam int unsigned SymW  = imtf_pkg::SymW;
  localparam int unsigned FillW = imtf_pkg::FillW;

  imtf_pkg::state_e state_q, state_d;

  logic [LaneW-1:0] lane_q;
  logic [SymW-1:0]  sym_q;
  logic             decode_q;
  logic             eob_q;
  logic [SymW-1:0]  rd_idx_q;
  logic [SymW-1:0]  cmp_idx_q;
  logic             cmp_vld_q;
  logic [SymW-1:0]  carry_q;
  logic [SymW-1:0]  result_q;
  logic [FillW-1:0] fill_q [MAX_LANES];

  logic [FillW-1:0] cur_fill;
  logic [SymW-1:0]  lookup_val;
  logic [SymW-1:0]  walk_val;
  logic             walk_hit;
  logic [FillW-1:0] new_fill;

  // Entries at or past the fill count still hold their identity value.
  assign cur_fill   = fill_q[lane_q];
  assign lookup_val = ({1'b0, sym_q} < cur_fill) ? mem_rdata_i : sym_q;
  assign walk_val   = ({1'b0, cmp_idx_q} < cur_fill) ? mem_rdata_i : cmp_idx_q;
  assign walk_hit   = cmp_vld_q && (walk_val == sym_q);
  assign new_fill   = {1'b0, cmp_idx_q} + FillW'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      imtf_pkg::StIdle: begin
        if (start_i.valid) begin
          state_d = start_i.decode ? imtf_pkg::StLookup : imtf_pkg::StWalk;
        end
      end
      imtf_pkg::StLookup:  state_d = imtf_pkg::StLookupW;
      imtf_pkg::StLookupW: state_d = imtf_pkg::StWalk;
      imtf_pkg::StWalk: begin
        if (walk_hit) begin
          state_d = imtf_pkg::StDone;
        end
      end
      imtf_pkg::StDone: begin
        if (done_ack_i) begin
          state_d = imtf_pkg::StIdle;
        end
      end
      default: state_d = imtf_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imtf_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk registers: read address runs one entry ahead of the compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else if (state_q == imtf_pkg::StWalk) begin
      cmp_vld_q <= !walk_hit;
    end else begin
      cmp_vld_q <= 1'b0;
    end
  end

  // Item payload and datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      imtf_pkg::StIdle: begin
        if (start_i.valid) begin
          lane_q   <= lane_i;
          sym_q    <= start_i.sym;
          carry_q  <= start_i.sym;
          decode_q <= start_i.decode;
          eob_q    <= start_i.eob;
          rd_idx_q <= '0;
        end
      end
      imtf_pkg::StLookupW: begin
        // Decode: the symbol at the rank becomes the search target.
        sym_q    <= lookup_val;
        carry_q  <= lookup_val;
        result_q <= lookup_val;
        rd_idx_q <= '0;
      end
      imtf_pkg::StWalk: begin
        rd_idx_q  <= rd_idx_q + SymW'(1);
        cmp_idx_q <= rd_idx_q;
        if (cmp_vld_q) begin
          carry_q <= walk_val;
          if (walk_hit && !decode_q) begin
            result_q <= cmp_idx_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Fill counts: grow to cover the shifted prefix, cleared at end of block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned l = 0; l < MAX_LANES; l++) begin
        fill_q[l] <= '0;
      end
    end else if (state_q == imtf_pkg::StWalk && walk_hit) begin
      if (eob_q) begin
        for (int unsigned l = 0; l < MAX_LANES; l++) begin
          fill_q[l] <= '0;
        end
      end else if (new_fill > cur_fill) begin
        fill_q[lane_q] <= new_fill;
      end
    end
  end

  // Memory access.
  always_comb begin
    mem_raddr_o = {lane_q, rd_idx_q};
    if (state_q == imtf_pkg::StLookup) begin
      mem_raddr_o = {lane_q, sym_q};
    end
  end

  assign mem_we_o    = (state_q == imtf_pkg::StWalk) && cmp_vld_q;
  assign mem_waddr_o = {lane_q, cmp_idx_q};
  assign mem_wdata_o = carry_q;

  assign idle_o        = (state_q == imtf_pkg::StIdle);
  assign done_o.valid  = (state_q == imtf_pkg::StDone);
  assign done_o.result = result_q;

endmodule

// File: hw/rtl/interleaved_move_to_front_codec.sv
// Top level of the interleaved move-to-front codec.
// An encode item walks its lane list until the symbol is found; a decode item first looks
// up the symbol at its rank, then walks. Item time is set by the serial walk over the lane
// list, one entry per cycle, plus output stalls. Input reopens once the result
// is registered. Reset: all lists read as identity through per-lane fill counts, lane 0,
// encode mode, 16 lanes; no memory clearing pass.
module interleaved_move_to_front_codec #(
  parameter int unsigned MAX_LANES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [imtf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [imtf_pkg::SymW-1:0]     in_byte_i,
  input  logic                          end_of_block_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [imtf_pkg::SymW-1:0]     out_byte_o
);

  localparam int unsigned LaneW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int unsigned AddrW = LaneW + imtf_pkg::SymW;
  localparam int unsigned CntW  = imtf_pkg::CntW;
  localparam logic [CntW-1:0] MaxLanesC = CntW'(MAX_LANES);

  logic                            mode_q;
  logic [imtf_pkg::CfgDataW-1:0]   lane_count_q;
  logic [LaneW-1:0]                pos_q;
  logic                            out_valid_q;
  logic [imtf_pkg::SymW-1:0]       out_byte_q;

  logic [CntW-1:0]                 count_raw;
  logic [CntW-1:0]                 count_eff;
  logic [LaneW-1:0]                lane;
  logic [CntW-1:0]                 lane_inc;
  logic [LaneW-1:0]                pos_next;
  logic                            in_fire;
  logic                            idle;
  logic                            done_ack;
  imtf_pkg::start_t                start;
  imtf_pkg::done_t                 done;

  logic                            mem_we;
  logic [AddrW-1:0]                mem_waddr;
  logic [imtf_pkg::SymW-1:0]       mem_wdata;
  logic [AddrW-1:0]                mem_raddr;
  logic [imtf_pkg::SymW-1:0]       mem_rdata;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= imtf_pkg::ModeEncode;
      lane_count_q <= imtf_pkg::LaneCountReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        imtf_pkg::RegMode:      mode_q       <= cfg_data_i[0];
        imtf_pkg::RegLaneCount: lane_count_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Effective lane count and the lane of the incoming item.
  assign count_raw = {1'b0, lane_count_q};

  always_comb begin
    count_eff = count_raw;
    if (count_raw == '0) begin
      count_eff = CntW'(1);
    end else if (count_raw > MaxLanesC) begin
      count_eff = MaxLanesC;
    end
  end

  assign lane     = (CntW'(pos_q) >= count_eff) ? '0 : pos_q;
  assign lane_inc = CntW'(lane) + CntW'(1);
  assign pos_next = (lane_inc >= count_eff) ? '0 : LaneW'(lane_inc);

  assign in_ready_o = idle;
  assign in_fire    = in_valid_i && in_ready_o;

  // Lane position advances on each item and returns to zero at end of block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      pos_q <= end_of_block_i ? '0 : pos_next;
    end
  end

  assign start.valid  = in_fire;
  assign start.decode = (mode_q == imtf_pkg::ModeDecode);
  assign start.eob    = end_of_block_i;
  assign start.sym    = in_byte_i;

  imtf_ctrl #(
    .MAX_LANES (MAX_LANES),
    .LaneW     (LaneW),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .lane_i      (lane),
    .idle_o      (idle),
    .done_o      (done),
    .done_ack_i  (done_ack),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  imtf_list_mem #(
    .AddrW (AddrW)
  ) u_list_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register; takes a finished item when empty or being drained.
  assign done_ack = done.valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_ack) begin
      out_byte_q <= done.result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  // An accepted item keeps the input closed on the next cycle.
  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_fire |=> !in_ready_o
  ) else $error("input ready right after an accepted item");

  // The lane position never leaves the lane range.
  a_pos_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni) CntW'(pos_q) < MaxLanesC
  ) else $error("lane position out of range");

  // An end-of-block item restarts the lane position at zero.
  a_eob_pos : assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_fire && end_of_block_i |=> pos_q == '0
  ) else $error("lane position not cleared at end of block");

  // The list memory is only written while an item is in work.
  a_write_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni) mem_we |-> !in_ready_o
  ) else $error("list write while idle");

endmodule
